@@ hdl/rf_switch_receive_controller_macros.svh @@
// Assertion macros for the switch receive controller.
`ifndef RF_SWITCH_RECEIVE_CONTROLLER_MACROS_SVH
`define RF_SWITCH_RECEIVE_CONTROLLER_MACROS_SVH

// Property checked at every rising clock edge, muted while reset is asserted.
`define RSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define RSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rsc_pkg.sv @@
// Types and constants shared by the switch receive controller modules.
package rsc_pkg;

  localparam int unsigned CW_W       = 16;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned LOST_W     = 11;
  localparam int unsigned INTERVAL_W = 8;
  localparam int unsigned REPEAT_W   = 16;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned LOSS_LIMIT_DEFAULT = 1000;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd100;
  localparam logic [REPEAT_W-1:0]   REPEAT_RESET   = 16'd90;

  localparam logic [7:0]        FRAME_LEN_CODE = 8'd11;
  localparam logic [LOST_W-1:0] LOST_MAX       = 11'h7FF;
  localparam logic [HOLD_W-1:0] HOLD_MAX       = 16'hFFFF;
  localparam logic [HOLD_W-1:0] HOLD_STEP      = 16'd2;
  localparam int unsigned       BIT_VALID      = 15;
  localparam int unsigned       BIT_AUX        = 14;

  typedef enum logic [0:0] {
    CFG_INTERVAL = 1'b0,
    CFG_REPEAT   = 1'b1
  } rsc_cfg_idx_e;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval_ms;
    logic [REPEAT_W-1:0]   repeat_count;
  } rsc_cfg_t;

  typedef struct packed {
    logic        irq_seen;
    logic [6:0]  rx_length;
    logic [7:0]  length_byte;
    logic [15:0] io_word;
    logic [15:0] analog_value;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [7:0]  spare_byte;
    logic [7:0]  packet_sum;
    logic        local_valid_low;
  } rsc_in_t;

  typedef struct packed {
    logic [CW_W-1:0] control_word;
    logic            drive_a;
    logic            drive_b;
    logic            finished;
    logic            was_check;
  } rsc_out_t;

endpackage

@@ hdl/rf_switch_receive_controller.sv @@
// Top level of the polled receive-side switch controller.
//
// Usage: each request on the input channel is one poll tick carrying the
// receive flag, the frame fields and the local valid pin. Ticks alternate
// arm / check, starting with arm after reset. Every tick yields exactly one
// result request: control word, its bits 14 and 15, finished, was_check.
// Channels: in_valid_i / in_stall_o / in_data_i, out_valid_o / out_stall_i /
// out_data_o. A request moves when valid is high and stall is low.
// Config: cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i; ready is
// always high, write only while no tick is in flight.
// Path: a tick enters the input register, then the decision logic updates
// the state and loads the result register.
// Throughput: 1 tick per cycle while the result register is not stalled.
// Reset (async, rst_ni low): state clears, interval 100, repeat count 90,
// both stages empty.
// Stall: a stalled result holds; one more tick can wait in the input
// register, after which in_stall_o rises.
module rf_switch_receive_controller #(
  parameter int unsigned LossLimit = rsc_pkg::LOSS_LIMIT_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rsc_pkg::rsc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rsc_pkg::rsc_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  rsc_pkg::rsc_cfg_idx_e          cfg_index_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rsc_pkg::*;
  `include "rf_switch_receive_controller_macros.svh"

  rsc_cfg_t cfg;
  rsc_in_t  s1_data_q;
  logic     s1_valid_q, s1_valid_d;
  rsc_out_t res, out_data_q;
  logic     out_valid_q, out_valid_d;
  logic     advance;   // input-stage tick is processed this cycle
  logic     in_take;   // new request accepted

  rsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result register free or draining this cycle
  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  rsc_tick #(
    .LossLimit (LossLimit)
  ) u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // once finished, only the local valid bit can be set in the word
  `RSC_ASSERT(a_finished_word_clear, clk_i, rst_ni,
    out_valid_o && out_data_o.finished |-> out_data_o.control_word[BIT_AUX:0] == '0,
    "finished with nonzero control bits")
  // drive pins follow the control word
  `RSC_ASSERT(a_drive_match, clk_i, rst_ni,
    out_valid_o |-> (out_data_o.drive_a == out_data_o.control_word[BIT_AUX])
      && (out_data_o.drive_b == out_data_o.control_word[BIT_VALID]),
    "drive bits disagree with control word")
  // a full pipe under output stall must push back on the input
  `RSC_ASSERT(a_backpressure, clk_i, rst_ni,
    s1_valid_q && out_valid_o && out_stall_i |=> s1_valid_q && $stable(s1_data_q),
    "input stage lost a tick under stall")

endmodule

@@ hdl/rsc_cfg.sv @@
// Configuration registers: poll interval and repeat count.
module rsc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  rsc_pkg::rsc_cfg_idx_e               cfg_index_i,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output rsc_pkg::rsc_cfg_t                   cfg_o
);
  import rsc_pkg::*;

  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [REPEAT_W-1:0]   repeat_q, repeat_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    interval_d = interval_q;
    repeat_d   = repeat_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INTERVAL: interval_d = cfg_data_i[INTERVAL_W-1:0];
        CFG_REPEAT:   repeat_d   = cfg_data_i[REPEAT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
      repeat_q   <= REPEAT_RESET;
    end else begin
      interval_q <= interval_d;
      repeat_q   <= repeat_d;
    end
  end

  assign cfg_o.interval_ms  = interval_q;
  assign cfg_o.repeat_count = repeat_q;

endmodule

@@ hdl/rsc_tick.sv @@
// Per-tick decision logic and the controller state it updates.
module rsc_tick #(
  parameter int unsigned LossLimit = rsc_pkg::LOSS_LIMIT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rsc_pkg::rsc_in_t  item_i,
  input  rsc_pkg::rsc_cfg_t cfg_i,
  output rsc_pkg::rsc_out_t res_o
);
  import rsc_pkg::*;

  localparam logic [LOST_W-1:0] LossLim = LOST_W'(LossLimit);

  logic [CW_W-1:0]   latch_q, latch_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic [LOST_W-1:0] lost_q, lost_d;
  logic              done_q, done_d;
  logic              phase_q;

  logic [7:0]        sum8;
  logic              frame_ok;
  logic [LOST_W:0]   lost_sum;
  logic [HOLD_W:0]   hold_sum;

  // 8-bit additive checksum over the nine payload bytes
  assign sum8 = item_i.io_word[7:0] + item_i.io_word[15:8]
              + item_i.analog_value[7:0] + item_i.analog_value[15:8]
              + item_i.source_address[7:0] + item_i.source_address[15:8]
              + item_i.dest_address[7:0] + item_i.dest_address[15:8]
              + item_i.spare_byte;

  assign frame_ok = (item_i.rx_length != 7'd0) && (item_i.length_byte == FRAME_LEN_CODE)
                 && (sum8 == item_i.packet_sum);

  always_comb begin
    latch_d  = latch_q;
    hold_d   = hold_q;
    lost_d   = lost_q;
    done_d   = done_q;
    lost_sum = {1'b0, lost_q} + {{(LOST_W + 1 - INTERVAL_W){1'b0}}, cfg_i.interval_ms};
    hold_sum = '0;
    if (phase_q) begin
      if (item_i.irq_seen) begin
        if (frame_ok && !done_q && (latch_q == '0)) begin
          latch_d = item_i.io_word;
          hold_d  = '0;
          lost_d  = '0;
        end
      end else begin
        lost_d = lost_sum[LOST_W] ? LOST_MAX : lost_sum[LOST_W-1:0];
        if (lost_d > LossLim) begin
          latch_d = '0;
          done_d  = 1'b0;
        end
      end
      hold_sum = {1'b0, hold_d} + {1'b0, HOLD_STEP};
      if (latch_d != '0) begin
        hold_d = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
        if (hold_d > cfg_i.repeat_count) begin
          latch_d = '0;
          done_d  = 1'b1;
        end
      end
    end
    if (item_i.local_valid_low) begin
      latch_d[BIT_VALID] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      hold_q  <= '0;
      lost_q  <= '0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (fire_i) begin
      latch_q <= latch_d;
      hold_q  <= hold_d;
      lost_q  <= lost_d;
      done_q  <= done_d;
      phase_q <= ~phase_q;
    end
  end

  assign res_o.control_word = latch_d;
  assign res_o.drive_a      = latch_d[BIT_AUX];
  assign res_o.drive_b      = latch_d[BIT_VALID];
  assign res_o.finished     = done_d;
  assign res_o.was_check    = phase_q;

endmodule

@@ test/rf_switch_receive_controller_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the switch controller: directed ticks, then random traffic.
module rf_switch_receive_controller_tb;
  import rsc_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1250;
  localparam int unsigned HOLDOFF_CYCLES  = 300;  // long receiver hold-off, fills the input stage
  localparam int unsigned DRAIN_MARGIN    = 4;    // input and result registers plus slack
  localparam int unsigned LONG_HOLD_TICKS = 200;  // ticks spent holding under the largest limit
  localparam int unsigned TIMEOUT_NS      = 3_200_000;

  // ---------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  rsc_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsc_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  rsc_cfg_idx_e          cfg_index_i = CFG_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  rf_switch_receive_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Switch predictor state: mirrors the controller after every accepted tick
  // ---------------------------------------------------------------------------
  logic [CW_W-1:0]       sw_latch    = '0;
  logic [HOLD_W-1:0]     sw_hold     = '0;
  logic [LOST_W-1:0]     sw_lost     = '0;
  logic                  sw_done     = 1'b0;
  logic                  sw_phase    = 1'b0;  // 0 = arm tick next, 1 = check tick next
  logic [INTERVAL_W-1:0] sw_interval = INTERVAL_RESET;
  logic [REPEAT_W-1:0]   sw_repeat   = REPEAT_RESET;

  rsc_out_t    expected_results[$];  // one entry per accepted tick, oldest first
  int unsigned mismatch_count = 0;

  // idle odds in percent, changed per test
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 49;

  logic        holdoff_arm  = 1'b0;
  int unsigned holdoff_left = 0;

  // 8-bit additive sum over the nine payload bytes, low byte of each word first
  function automatic logic [7:0] frame_sum(input rsc_in_t t);
    return t.io_word[7:0] + t.io_word[15:8]
         + t.analog_value[7:0] + t.analog_value[15:8]
         + t.source_address[7:0] + t.source_address[15:8]
         + t.dest_address[7:0] + t.dest_address[15:8]
         + t.spare_byte;
  endfunction

  // Advances the predictor by one poll tick and returns the result it implies.
  function automatic rsc_out_t step_switch_model(input rsc_in_t t);
    int unsigned lost_n;
    int unsigned hold_n;
    rsc_out_t    r;
    if (sw_phase) begin
      if (t.irq_seen) begin
        // frame accepted only into an empty latch of an unfinished task
        if (t.rx_length != 0 && t.length_byte == FRAME_LEN_CODE &&
            frame_sum(t) == t.packet_sum && !sw_done && sw_latch == '0) begin
          sw_latch = t.io_word;
          sw_hold  = '0;
          sw_lost  = '0;
        end
      end else begin
        // missed check: lost time grows, saturating
        lost_n = sw_lost + sw_interval;
        if (lost_n > LOST_MAX) lost_n = LOST_MAX;
        sw_lost = lost_n[LOST_W-1:0];
        if (lost_n > LOSS_LIMIT_DEFAULT) begin
          sw_latch = '0;
          sw_done  = 1'b0;
        end
      end
      if (sw_latch != '0) begin
        hold_n = sw_hold + HOLD_STEP;
        if (hold_n > HOLD_MAX) hold_n = HOLD_MAX;
        sw_hold = hold_n[HOLD_W-1:0];
        if (hold_n > sw_repeat) begin
          sw_latch = '0;
          sw_done  = 1'b1;
        end
      end
    end
    r.was_check = sw_phase;
    sw_phase    = ~sw_phase;
    // local valid pin low forces bit 15 on every tick, arm or check
    if (t.local_valid_low) sw_latch[BIT_VALID] = 1'b1;
    r.control_word = sw_latch;
    r.drive_a      = sw_latch[BIT_AUX];
    r.drive_b      = sw_latch[BIT_VALID];
    r.finished     = sw_done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick builders
  // ---------------------------------------------------------------------------
  function automatic rsc_in_t good_frame(input logic [15:0] word, input logic lvl);
    rsc_in_t t;
    t.irq_seen        = 1'b1;
    t.rx_length       = 7'($urandom_range(64, 1));
    t.length_byte     = FRAME_LEN_CODE;
    t.io_word         = word;
    t.analog_value    = 16'($urandom);
    t.source_address  = 16'($urandom);
    t.dest_address    = 16'($urandom);
    t.spare_byte      = 8'($urandom);
    t.local_valid_low = lvl;
    t.packet_sum      = frame_sum(t);
    return t;
  endfunction

  // no receive flag: counts as a missed check
  function automatic rsc_in_t miss_tick();
    rsc_in_t t;
    t = good_frame(16'($urandom), 1'b0);
    t.irq_seen = 1'b0;
    if ($urandom_range(1)) t.packet_sum = 8'($urandom);
    return t;
  endfunction

  // Mostly well-formed frames; the rest are misses and broken frames.
  function automatic rsc_in_t random_tick();
    int unsigned pick;
    rsc_in_t     t;
    pick = $urandom_range(99);
    t    = good_frame(16'($urandom), $urandom_range(99) < 8);
    if (pick < 20) begin
      t.irq_seen = 1'b0;
    end else if (pick < 27) begin
      t.rx_length = '0;
    end else if (pick < 34) begin
      t.length_byte = 8'($urandom);
    end else if (pick < 41) begin
      t.packet_sum = t.packet_sum ^ 8'($urandom_range(255, 1));
    end else if (pick < 44) begin
      t.io_word    = '0;
      t.packet_sum = frame_sum(t);
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------
  // Offers one tick; valid stays high after acceptance so back-to-back
  // requests need no low cycle. Anything that waits afterwards drops valid.
  task automatic send_tick(input rsc_in_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(step_switch_model(t));
  endtask

  // Lands the tick on a check phase, inserting a missed arm tick if needed.
  task automatic send_check(input rsc_in_t t);
    if (!sw_phase) send_tick(miss_tick());
    send_tick(t);
  endtask

  // Sender pause: nothing offered until every outstanding result is back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_MARGIN) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input rsc_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_INTERVAL: sw_interval = data[INTERVAL_W-1:0];
      CFG_REPEAT:   sw_repeat   = data[REPEAT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input rsc_out_t got);
    rsc_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result request with nothing outstanding: %h", got));
    end else begin
      want = expected_results.pop_front();
      if (got.control_word !== want.control_word)
        report_mismatch($sformatf("control_word got %h want %h",
                                  got.control_word, want.control_word));
      if (got.drive_a !== want.drive_a)
        report_mismatch($sformatf("drive_a got %b want %b", got.drive_a, want.drive_a));
      if (got.drive_b !== want.drive_b)
        report_mismatch($sformatf("drive_b got %b want %b", got.drive_b, want.drive_b));
      if (got.finished !== want.finished)
        report_mismatch($sformatf("finished got %b want %b", got.finished, want.finished));
      if (got.was_check !== want.was_check)
        report_mismatch($sformatf("was_check got %b want %b", got.was_check, want.was_check));
    end
  endtask

  // Long hold-off counter, armed by a test with a one-cycle pulse.
  always @(posedge clk_i) begin : holdoff_counter
    if (holdoff_arm) begin
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Receiver: samples pre-edge values, then picks the next stall level.
  always @(posedge clk_i) begin : result_monitor
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    out_stall_i <= (holdoff_left != 0) || ($urandom_range(99) < rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset config. Arm tick ignores frames; rejects; word zero; accept; busy latch.
  task automatic test_frame_accept();
    rsc_in_t t;
    send_tick(good_frame(16'h4001, 1'b0));  // arm phase: good frame has no effect
    t = good_frame(16'h00FF, 1'b0);
    t.rx_length = '0;
    send_check(t);
    t = good_frame(16'h00FF, 1'b0);
    t.length_byte = FRAME_LEN_CODE + 8'd1;
    send_check(t);
    t = good_frame(16'h00FF, 1'b0);
    t.packet_sum = ~t.packet_sum;
    send_check(t);
    // all-zero frame is accepted but leaves the latch empty
    t = good_frame(16'h0000, 1'b0);
    t.analog_value   = '0;
    t.source_address = '0;
    t.dest_address   = '0;
    t.spare_byte     = '0;
    t.packet_sum     = frame_sum(t);
    send_check(t);
    t = good_frame(16'hC000, 1'b0);  // drives both outputs
    t.rx_length = 7'd64;
    send_check(t);
    // latch busy: this frame is dropped
    t = good_frame(16'h1234, 1'b0);
    t.rx_length      = 7'd1;
    t.analog_value   = '1;
    t.source_address = '1;
    t.dest_address   = '1;
    t.spare_byte     = '1;
    t.packet_sum     = frame_sum(t);
    send_check(t);
    t = miss_tick();  // arm tick with local valid low
    t.local_valid_low = 1'b1;
    send_tick(t);
  endtask

  // Hold count past the repeat count finishes the task; later frames are ignored.
  task automatic test_hold_finish();
    rsc_in_t t;
    wait_results_drained();
    write_reg(CFG_REPEAT, '0);
    t = good_frame(16'h0F0F, 1'b0);
    t.packet_sum = ~t.packet_sum;
    send_check(t);
    send_check(good_frame(16'h0F0F, 1'b0));
  endtask

  // Missed checks pile up lost time to saturation; loss clears finished.
  task automatic test_loss_timeout();
    wait_results_drained();
    write_reg(CFG_INTERVAL, {8'h00, 8'hFF});
    write_reg(CFG_REPEAT, REPEAT_RESET);
    repeat (9) send_check(miss_tick());
    send_check(good_frame(16'hFFFF, 1'b1));
    send_check(miss_tick());
  endtask

  // Receiver holds off while the sender keeps offering: input stall must rise.
  task automatic test_backpressure();
    wait_results_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holdoff_arm <= 1'b1;
    @(posedge clk_i);
    holdoff_arm <= 1'b0;
    repeat (40) send_tick(random_tick());
    wait_results_drained();
  endtask

  // Long hold under the largest repeat count, then a lower repeat count finishes.
  task automatic test_hold_saturation();
    wait_results_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_INTERVAL, {8'h00, 8'hFF});
    write_reg(CFG_REPEAT, HOLD_MAX);
    // force a loss so the latch is empty and the task unfinished
    while (sw_lost <= LOSS_LIMIT_DEFAULT || sw_latch != '0 || sw_done) send_check(miss_tick());
    send_check(good_frame(16'h4000, 1'b0));
    wait_results_drained();
    write_reg(CFG_INTERVAL, '0);
    repeat (LONG_HOLD_TICKS) send_tick(random_tick());
    wait_results_drained();
    write_reg(CFG_REPEAT, 16'd100);
    repeat (4) send_tick(random_tick());
  endtask

  // Three random phases with different idling and register settings.
  task automatic test_random_traffic();
    for (int p = 0; p < 3; p++) begin
      wait_results_drained();
      case (p)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 49;
          write_reg(CFG_INTERVAL, {8'($urandom), 8'hFF});  // upper byte is don't-care
          write_reg(CFG_REPEAT, '0);
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 37;
          write_reg(CFG_INTERVAL, 16'($urandom_range(255, 1)));
          write_reg(CFG_REPEAT, 16'($urandom_range(300)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(CFG_INTERVAL, 16'($urandom_range(140, 60)));
          write_reg(CFG_REPEAT, 16'($urandom_range(120, 20)));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        send_tick(random_tick());
        if ($urandom_range(199) == 0) wait_results_drained();
      end
    end
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_accept();
    test_hold_finish();
    test_loss_timeout();
    test_backpressure();
    test_hold_saturation();
    test_random_traffic();
    wait_results_drained();
    repeat (DRAIN_MARGIN) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hang or a result that never arrives ends here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
